// File: hdl/isetb_pkg.sv
// ----------------------------------------------------------------------------
// isetb_pkg
// Shared types and constants for the integer set table: command codes,
// result record and the biased bounds used by the range search.
// ----------------------------------------------------------------------------
package isetb_pkg;

    // Default number of table slots
    localparam int ISETB_CAPACITY = 64;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;
    localparam int CMD_W   = 2;

    // Flipping the sign bit makes unsigned order match signed order
    localparam logic [VALUE_W-1:0] SIGN_BIAS  = 32'h8000_0000;
    // INT_MAX and INT_MIN in biased form
    localparam logic [VALUE_W-1:0] BIASED_MAX = 32'hFFFF_FFFF;
    localparam logic [VALUE_W-1:0] BIASED_MIN = 32'h0000_0000;

    // Request kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_RANGE  = 2'd3
    } t_cmd;

    // One result record handed from the sequencer to the output stage
    typedef struct packed {
        logic [VALUE_W-1:0] range_value;
        logic               empty_res;
        logic [COUNT_W-1:0] element_count;
        logic               full_reject;
        logic               success;
    } t_result;

endpackage

// File: hdl/isetb_mem.sv
// ----------------------------------------------------------------------------
// isetb_mem
// Slot memory: one write port and one read port, registered read data.
// Each word holds a valid mark above the stored value.
// ----------------------------------------------------------------------------
module isetb_mem
    import isetb_pkg::*;
#(
    parameter int DEPTH = ISETB_CAPACITY,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [VALUE_W:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [VALUE_W:0] o_rdata
);

    logic [VALUE_W:0] r_mem [DEPTH];
    logic [VALUE_W:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/isetb_ctrl.sv
// ----------------------------------------------------------------------------
// isetb_ctrl
// Request sequencer: clears the slot memory after reset, then per request
// scans every slot once, applies the change and produces one result.
// ----------------------------------------------------------------------------
module isetb_ctrl
    import isetb_pkg::*;
#(
    parameter int CAPACITY = ISETB_CAPACITY,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CNTW     = $clog2(CAPACITY + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               i_req_valid,
    output logic               o_req_ready,
    input  t_cmd               i_req_cmd,
    input  logic [VALUE_W-1:0] i_req_value,
    // result side
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output t_result            o_res,
    // slot memory
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic [VALUE_W:0]   o_mem_wdata,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic [VALUE_W:0]   i_mem_rdata
);

    localparam logic [AW-1:0]   LAST_ADDR = AW'(CAPACITY - 1);
    localparam logic [CNTW-1:0] CAP_COUNT = CNTW'(CAPACITY);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_DONE   = 5'b10000
    } t_state;

    // control state
    t_state          r_state, n_state;
    logic [CNTW-1:0] r_count, n_count;
    logic [AW-1:0]   r_addr, n_addr;
    logic            r_issue_done, n_issue_done;
    logic            r_pend, n_pend;
    // request and scan payload
    logic [AW-1:0]      r_pend_idx, n_pend_idx;
    t_cmd               r_cmd, n_cmd;
    logic [VALUE_W-1:0] r_value, n_value;
    logic               r_found, n_found;
    logic [AW-1:0]      r_found_idx, n_found_idx;
    logic               r_free, n_free;
    logic [AW-1:0]      r_free_idx, n_free_idx;
    logic               r_any, n_any;
    logic [VALUE_W-1:0] r_lo, n_lo;
    logic [VALUE_W-1:0] r_hi, n_hi;
    t_result            r_res, n_res;

    logic               w_slot_valid;
    logic [VALUE_W-1:0] w_slot_key;

    assign w_slot_valid = i_mem_rdata[VALUE_W];
    assign w_slot_key   = i_mem_rdata[VALUE_W-1:0] ^ SIGN_BIAS;

    // Sequencer and scan accumulators
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_pend       = 1'b0;
        n_pend_idx   = r_pend_idx;
        n_cmd        = r_cmd;
        n_value      = r_value;
        n_found      = r_found;
        n_found_idx  = r_found_idx;
        n_free       = r_free;
        n_free_idx   = r_free_idx;
        n_any        = r_any;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_res        = r_res;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_addr;
        o_mem_wdata  = '0;

        unique case (r_state)
            ST_CLEAR: begin
                // sweep the memory, one slot a cycle
                o_mem_we = 1'b1;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_state      = ST_SCAN;
                    n_cmd        = i_req_cmd;
                    n_value      = i_req_value;
                    n_addr       = '0;
                    n_issue_done = 1'b0;
                    n_found      = 1'b0;
                    n_free       = 1'b0;
                    n_any        = 1'b0;
                    n_lo         = BIASED_MAX;
                    n_hi         = BIASED_MIN;
                end
            end
            ST_SCAN: begin
                // issue the next read
                if (!r_issue_done) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_addr;
                    if (r_addr == LAST_ADDR) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                // fold in the slot read last cycle
                if (r_pend) begin
                    if (w_slot_valid) begin
                        n_any = 1'b1;
                        if (w_slot_key < r_lo) n_lo = w_slot_key;
                        if (w_slot_key > r_hi) n_hi = w_slot_key;
                        if (!r_found && i_mem_rdata[VALUE_W-1:0] == r_value) begin
                            n_found     = 1'b1;
                            n_found_idx = r_pend_idx;
                        end
                    end else if (!r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_pend_idx;
                    end
                    if (r_pend_idx == LAST_ADDR) begin
                        n_state = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE: begin
                // apply the change and build the result
                n_res.success     = 1'b0;
                n_res.full_reject = 1'b0;
                n_res.range_value = '0;
                case (r_cmd)
                    CMD_ADD: begin
                        if (!r_found) begin
                            if (r_count >= CAP_COUNT || !r_free) begin
                                n_res.full_reject = 1'b1;
                            end else begin
                                o_mem_we      = 1'b1;
                                o_mem_waddr   = r_free_idx;
                                o_mem_wdata   = {1'b1, r_value};
                                n_count       = r_count + CNTW'(1);
                                n_res.success = 1'b1;
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_found) begin
                            o_mem_we      = 1'b1;
                            o_mem_waddr   = r_found_idx;
                            o_mem_wdata   = {1'b0, r_value};
                            if (r_count != '0) n_count = r_count - CNTW'(1);
                            n_res.success = 1'b1;
                        end
                    end
                    CMD_QUERY: begin
                        n_res.success = r_found;
                    end
                    default: begin
                        if (r_any) begin
                            n_res.success     = 1'b1;
                            n_res.range_value = r_hi - r_lo;
                        end
                    end
                endcase
                n_res.element_count = COUNT_W'(n_count);
                n_res.empty_res     = (n_count == '0);
                n_state             = ST_DONE;
            end
            ST_DONE: begin
                // hold the result until the output stage takes it
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_count      <= '0;
            r_addr       <= '0;
            r_issue_done <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_pend       <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx  <= n_pend_idx;
        r_cmd       <= n_cmd;
        r_value     <= n_value;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
        r_free      <= n_free;
        r_free_idx  <= n_free_idx;
        r_any       <= n_any;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_res       <= n_res;
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;
    assign o_mem_raddr = r_addr;

endmodule

// File: hdl/integer_set_table_top.sv
// ----------------------------------------------------------------------------
// integer_set_table_top
// Bounded set of signed 32-bit integers with add, remove, membership query
// and range (maximum minus minimum) requests, held in a scanned slot memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  tdata (low bit up)                       tuser
//  s_axis    in         value[31:0]                              command[1:0]
//  m_axis    out        success, full_reject, element_count[6:0],  -
//                       empty_res, range_value[31:0], zero pad
//
//  A request passes through a read pass over every slot (registered read
//  data), an update step and a handoff to the output register before its
//  result shows on m_axis; the block then returns to idle for the next request.
//  After reset the slot memory is swept clear, during which s_axis_tready
//  stays low. A result waits in the output register while
//  the next request is accepted; a stalled m_axis holds further results back.
// ----------------------------------------------------------------------------
module integer_set_table_top
    import isetb_pkg::*;
#(
    parameter int CAPACITY = ISETB_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // value[31:0]
    input  logic [1:0]  i_s_axis_tuser,   // command[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // success, full_reject, element_count[6:0],
                                          // empty_res, range_value[31:0], pad[47:42]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic             w_mem_we;
    logic [AW-1:0]    w_mem_waddr;
    logic [VALUE_W:0] w_mem_wdata;
    logic [AW-1:0]    w_mem_raddr;
    logic [VALUE_W:0] w_mem_rdata;
    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;

    logic             r_out_valid;
    logic [47:0]      r_out_data;

    isetb_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    isetb_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req_cmd   (t_cmd'(i_s_axis_tuser)),
        .i_req_value (i_s_axis_tdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    // Output register: load when empty or when the held transaction leaves
    assign w_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_data <= {6'b0, w_res.range_value, w_res.empty_res,
                           w_res.element_count, w_res.full_reject, w_res.success};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: hdl/isetb_checker.sv
// ----------------------------------------------------------------------------
// isetb_checker
// Port-level checks for the integer set table, bound to the top level.
// ----------------------------------------------------------------------------
module isetb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    // Reset starts the clearing sweep, so no request is taken right after it
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("request accepted during memory clear");

    // One request at a time: the scan follows every accepted transaction
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second request accepted while scanning");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // A rejected add never reports success
    a_reject_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> !o_m_axis_tdata[0])
        else $error("full reject with success");

    // An empty set reports a zero count and a zero range
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[9] |->
            o_m_axis_tdata[8:2] == 7'd0 && o_m_axis_tdata[41:10] == 32'd0)
        else $error("empty set with count or range");

endmodule

bind integer_set_table_top isetb_checker u_isetb_checker (.*);

// File: tb/sv/integer_set_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_set_table_top_tb
// Self-checking bench for the integer set table. A short directed sequence
// walks the corner cases: empty range, absent lookups, duplicate adds, the
// 32-bit extremes and slot reuse. Random rounds then fill the table past
// capacity, churn it and drain it again. A local model of the set predicts
// every result. Both stream sides idle at random, and the result side holds
// off once for a long stretch so that the request side backs up.
// ----------------------------------------------------------------------------
module integer_set_table_top_tb;
    import isetb_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 4;
    localparam int BLOCK_LATENCY  = ISETB_CAPACITY + 3;
    localparam int RUN_LIMIT      = 600_000;
    localparam int IDLE_PCT       = 14;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int HOLDOFF_AT     = 900;
    localparam int QUIET_FROM     = 500;
    localparam int QUIET_TO       = 700;
    localparam int POOL_SIZE      = 72;
    localparam int ROUNDS         = 7;
    localparam int ROUND_ITEMS    = 200;

    localparam logic [VALUE_W-1:0] INT_MAX_V = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] INT_MIN_V = 32'h8000_0000;

    // Random rounds cycle through these phases
    localparam int PHASE_FILL  = 0;
    localparam int PHASE_CHURN = 1;
    localparam int PHASE_DRAIN = 2;

    typedef struct {
        t_cmd               cmd;
        logic [VALUE_W-1:0] value;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // value[31:0]
    logic [1:0]  i_s_axis_tuser = '0;   // command[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [47:0] o_m_axis_tdata;        // success, full_reject, element_count[6:0],
                                        // empty_res, range_value[31:0], pad

    // Requests waiting to be sent, and results the set model predicts
    t_request pending_requests[$];
    t_result  expected_results[$];

    // Set model state
    logic [VALUE_W-1:0] model_value [ISETB_CAPACITY];
    bit                 model_valid [ISETB_CAPACITY];
    int                 model_count = 0;

    int  cycle_count = 0;
    int  requests_taken = 0;
    int  results_checked = 0;
    int  errors = 0;
    int  full_rejects = 0;
    int  peak_count = 0;
    int  holdoff_left = 0;
    bit  holdoff_done = 1'b0;
    bit  s_fired = 1'b0;
    bit  quiet;

    integer_set_table_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Turn off idling on both sides for one stretch of requests
    assign quiet = (requests_taken >= QUIET_FROM) && (requests_taken < QUIET_TO);

    // Apply one request to the set model and return its result
    function automatic t_result apply_set_request(t_request req);
        t_result            res;
        int                 hit_idx;
        int                 free_idx;
        logic [VALUE_W-1:0] key;
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        bit                 found_any;
        res       = '0;
        hit_idx   = -1;
        free_idx  = -1;
        lo        = BIASED_MAX;
        hi        = BIASED_MIN;
        found_any = 1'b0;
        for (int i = 0; i < ISETB_CAPACITY; i++) begin
            if (model_valid[i] && model_value[i] == req.value && hit_idx < 0)
                hit_idx = i;
            if (!model_valid[i] && free_idx < 0)
                free_idx = i;
        end
        case (req.cmd)
            CMD_ADD: begin
                if (hit_idx < 0) begin
                    if (free_idx < 0 || model_count >= ISETB_CAPACITY) begin
                        res.full_reject = 1'b1;
                        full_rejects++;
                    end else begin
                        model_value[free_idx] = req.value;
                        model_valid[free_idx] = 1'b1;
                        model_count++;
                        res.success = 1'b1;
                    end
                end
            end
            CMD_REMOVE: begin
                if (hit_idx >= 0) begin
                    model_valid[hit_idx] = 1'b0;
                    if (model_count > 0)
                        model_count--;
                    res.success = 1'b1;
                end
            end
            CMD_QUERY: begin
                res.success = (hit_idx >= 0);
            end
            default: begin
                // Bias the sign bit so unsigned compare follows signed order
                for (int i = 0; i < ISETB_CAPACITY; i++) begin
                    if (model_valid[i]) begin
                        key = model_value[i] ^ SIGN_BIAS;
                        if (key < lo)
                            lo = key;
                        if (key > hi)
                            hi = key;
                        found_any = 1'b1;
                    end
                end
                if (found_any) begin
                    res.success     = 1'b1;
                    res.range_value = hi - lo;
                end
            end
        endcase
        res.element_count = COUNT_W'(model_count);
        res.empty_res     = (model_count == 0);
        if (model_count > peak_count)
            peak_count = model_count;
        return res;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic push_request(t_cmd cmd, logic [VALUE_W-1:0] value);
        t_request req;
        req.cmd   = cmd;
        req.value = value;
        pending_requests.push_back(req);
    endtask

    // Sample both handshakes; predict accepted requests, check accepted results
    always @(posedge i_clk) begin
        t_request req;
        t_result  got;
        t_result  want;
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end else begin
            s_fired = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
            if (s_fired && pending_requests.size() != 0) begin
                req = pending_requests.pop_front();
                expected_results.push_back(apply_set_request(req));
                requests_taken++;
            end
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_result'(o_m_axis_tdata[$bits(t_result)-1:0]);
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: 0x%0h", o_m_axis_tdata);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("success", want.success, got.success);
                    check_field("full_reject", want.full_reject, got.full_reject);
                    check_field("element_count", want.element_count, got.element_count);
                    check_field("empty_res", want.empty_res, got.empty_res);
                    check_field("range_value", want.range_value, got.range_value);
                end
                results_checked++;
            end
        end
    end

    // Drive requests; hold a transaction until it is taken, idle at random otherwise
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!(i_s_axis_tvalid && !s_fired)) begin
            if (pending_requests.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= pending_requests[0].value;
                i_s_axis_tuser  <= pending_requests[0].cmd;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Drive result-side ready; stall at random, and hold off once for a long stretch
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (holdoff_left != 0) begin
            i_m_axis_tready <= 1'b0;
            holdoff_left--;
        end else if (!holdoff_done && results_checked >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Build stimulus, run reset, wait for the drain, report
    initial begin
        logic [VALUE_W-1:0] pool [POOL_SIZE];
        int                 add_cut [3];
        int                 rem_cut [3];
        int                 phase;
        int                 roll;
        int                 seq_idx;
        t_cmd               cmd;
        logic [VALUE_W-1:0] value;
        // Cumulative weights per phase: add, then remove; query and range split the rest
        add_cut = '{65, 35, 10};
        rem_cut = '{75, 65, 75};
        seq_idx = 0;

        // Directed: empty set, absent items, extremes, duplicates, slot reuse
        push_request(CMD_RANGE, $urandom);
        push_request(CMD_QUERY, 32'd5);
        push_request(CMD_REMOVE, 32'd5);
        push_request(CMD_ADD, INT_MIN_V);
        push_request(CMD_RANGE, 32'd0);
        push_request(CMD_ADD, INT_MAX_V);
        push_request(CMD_RANGE, 32'hFFFF_FFFF);
        push_request(CMD_ADD, INT_MAX_V);
        push_request(CMD_QUERY, INT_MAX_V);
        push_request(CMD_QUERY, INT_MIN_V);
        push_request(CMD_ADD, 32'd0);
        push_request(CMD_ADD, 32'hFFFF_FFFF);
        push_request(CMD_REMOVE, INT_MIN_V);
        push_request(CMD_RANGE, 32'd0);
        push_request(CMD_ADD, INT_MIN_V);
        push_request(CMD_REMOVE, INT_MAX_V);
        push_request(CMD_REMOVE, INT_MAX_V);
        push_request(CMD_RANGE, 32'd0);
        push_request(CMD_REMOVE, 32'd0);
        push_request(CMD_REMOVE, 32'hFFFF_FFFF);
        push_request(CMD_REMOVE, INT_MIN_V);
        push_request(CMD_RANGE, 32'd0);

        // Random rounds: fill past capacity, churn, drain, over a shared value pool
        for (int r = 0; r < ROUNDS; r++) begin
            phase = r % 3;
            if (phase == PHASE_FILL) begin
                for (int i = 0; i < POOL_SIZE; i++)
                    pool[i] = (i % 4 == 1) ? 32'($urandom_range(200)) - 32'd100 : $urandom;
                pool[$urandom_range(POOL_SIZE-1)] = INT_MIN_V;
                pool[$urandom_range(POOL_SIZE-1)] = INT_MAX_V;
            end
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < add_cut[phase])
                    cmd = CMD_ADD;
                else if (roll < rem_cut[phase] + (phase == PHASE_CHURN ? 0 : 0))
                    cmd = CMD_REMOVE;
                else if (roll < 90)
                    cmd = CMD_QUERY;
                else
                    cmd = CMD_RANGE;
                // Walk the pool in order when filling or draining so the table
                // really reaches full and empty
                if ($urandom_range(99) < 15)
                    value = $urandom;
                else if ((phase == PHASE_FILL && cmd == CMD_ADD)
                         || (phase == PHASE_DRAIN && cmd == CMD_REMOVE))
                    value = pool[seq_idx++ % POOL_SIZE];
                else
                    value = pool[$urandom_range(POOL_SIZE-1)];
                push_request(cmd, value);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (2 * BLOCK_LATENCY) @(posedge i_clk);

        $display("Covered %0d requests and checked %0d results over %0d cycles",
                 requests_taken, results_checked, cycle_count);
        $display("Table peaked at %0d entries; %0d adds refused on a full table",
                 peak_count, full_rejects);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/isetb_pkg.sv
hdl/isetb_mem.sv
hdl/isetb_ctrl.sv
hdl/integer_set_table_top.sv
hdl/isetb_checker.sv
tb/sv/integer_set_table_top_tb.sv
